// ===== hw/rtl/wcpm_pkg.sv =====
// Shared types, character codes and pattern helper functions for the
// wildcard class pattern matcher. No dependencies.
package wcpm_pkg;

  localparam int LEN_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH     = 2'd2;

  // Pattern and text character codes
  localparam logic [CHAR_W-1:0] CH_ANY_LETTER = 8'h41;
  localparam logic [CHAR_W-1:0] CH_ANY_DIGIT  = 8'h44;
  localparam logic [CHAR_W-1:0] CH_ANY_BYTE   = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CASE_GAP   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BANG       = 8'h21;
  localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DASH       = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SEMI       = 8'h3B;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic char_allowed(input logic [CHAR_W-1:0] c);
    return is_lower(c) || (c == CH_ANY_LETTER) || (c == CH_ANY_DIGIT) ||
           (c == CH_ANY_BYTE) || (c == CH_BANG) || (c == CH_COMMA) ||
           (c == CH_DOT) || (c == CH_DASH) || (c == CH_COLON) || (c == CH_SEMI);
  endfunction

  function automatic logic char_matches(input logic [CHAR_W-1:0] p,
                                        input logic [CHAR_W-1:0] t);
    logic m;
    if (p == CH_ANY_LETTER) begin
      m = is_upper(t) || is_lower(t);
    end else if (p == CH_ANY_DIGIT) begin
      m = is_digit(t);
    end else if (p == CH_ANY_BYTE) begin
      m = 1'b1;
    end else if (is_lower(p)) begin
      m = (t == p) || (t == (p - CH_CASE_GAP));
    end else begin
      m = (t == p);
    end
    return m;
  endfunction

  // Characters past the second register read as zero, which is disallowed
  function automatic logic [CHAR_W-1:0] pat_char(input logic [CFG_DATA_W-1:0] low,
                                                 input logic [CFG_DATA_W-1:0] high,
                                                 input int i);
    logic [CHAR_W-1:0] c;
    if (i >= 0 && i < 8) begin
      c = low[i*CHAR_W +: CHAR_W];
    end else if (i >= 8 && i < 16) begin
      c = high[(i-8)*CHAR_W +: CHAR_W];
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/wcpm_front.sv =====
// Front end: configuration registers, byte window and pattern check.
// Pushes a window snapshot per match into the record queue. Uses wcpm_pkg.
module wcpm_front #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [wcpm_pkg::CHAR_W-1:0]            text_byte,
  input  logic                                   string_start,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wcpm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wcpm_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   rec_push,
  output logic [wcpm_pkg::LEN_W+PATTERN_MAX*wcpm_pkg::CHAR_W-1:0] rec_data,
  input  wcpm_pkg::q_status_t                    q_status
);
  import wcpm_pkg::*;

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] pattern_chars_low;
  logic [CFG_DATA_W-1:0] pattern_chars_high;

  logic [CHAR_W-1:0] window [PATTERN_MAX];
  logic [FILL_W-1:0] window_fill;
  logic [FILL_W-1:0] window_fill_next;
  logic              check_pending;

  logic                          accept;
  logic                          len_ok;
  logic                          lanes_ok;
  logic                          hit;
  logic [PATTERN_MAX*CHAR_W-1:0] win_flat;

  assign cfg_ready = 1'b1;
  assign full      = check_pending && q_status.full;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_chars_low  <= '0;
      pattern_chars_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[LEN_W-1:0];
        REG_CHARS_LOW:      pattern_chars_low  <= cfg_data;
        REG_CHARS_HIGH:     pattern_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (string_start) begin
      window_fill_next = FILL_W'(1);
    end else if (int'(window_fill) < PATTERN_MAX) begin
      window_fill_next = window_fill + FILL_W'(1);
    end else begin
      window_fill_next = window_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill   <= '0;
      check_pending <= 1'b0;
    end else begin
      if (accept) begin
        window_fill <= window_fill_next;
      end
      if (accept) begin
        check_pending <= 1'b1;
      end else if (!q_status.full) begin
        check_pending <= 1'b0;
      end
    end
  end

  // Window bytes need no reset: the fill count masks stale entries
  always_ff @(posedge clk) begin
    if (accept) begin
      window[0] <= text_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  // Compare the registered window, one lane per window position
  always_comb begin
    logic [CHAR_W-1:0] pc;
    int                pidx;
    pc       = '0;
    pidx     = 0;
    len_ok   = (pattern_length != '0) && (int'(pattern_length) <= PATTERN_MAX) &&
               (int'(window_fill) >= int'(pattern_length));
    lanes_ok = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (j < int'(pattern_length)) begin
        pidx = int'(pattern_length) - 1 - j;
        pc   = pat_char(pattern_chars_low, pattern_chars_high, pidx);
        if (!char_allowed(pc) || !char_matches(pc, window[j])) begin
          lanes_ok = 1'b0;
        end
      end
    end
    hit = len_ok && lanes_ok;
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_flat[i*CHAR_W +: CHAR_W] = window[i];
    end
  end

  assign rec_push = check_pending && !q_status.full && hit;
  assign rec_data = {pattern_length, win_flat};

endmodule

// ===== hw/rtl/wcpm_queue.sv =====
// Short register queue holding match records between front and back.
// Uses wcpm_pkg for the status struct.
module wcpm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic                rd_en,
  output logic [WIDTH-1:0]    rd_data,
  output wcpm_pkg::q_status_t status
);
  import wcpm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign rd_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/wcpm_back.sv =====
// Back end: takes one match record at a time and emits its bytes, oldest
// first, through an output register. Uses wcpm_pkg.
module wcpm_back #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [wcpm_pkg::LEN_W+PATTERN_MAX*wcpm_pkg::CHAR_W-1:0] rec_data,
  input  wcpm_pkg::q_status_t                    q_status,
  output logic                                   q_pop,
  output logic [wcpm_pkg::CHAR_W-1:0]            match_byte,
  output logic                                   match_end,
  output logic                                   empty,
  input  logic                                   pop
);
  import wcpm_pkg::*;

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int WIN_W = PATTERN_MAX * CHAR_W;

  logic [LEN_W-1:0]  rec_len;
  logic [31:0]       start_pos;
  logic              busy;
  logic [IDX_W-1:0]  pos;
  logic [WIN_W-1:0]  cur_win;
  logic              out_valid;
  logic              out_free;
  logic              load_out;
  logic              last;

  assign rec_len   = rec_data[LEN_W+WIN_W-1 -: LEN_W];
  assign start_pos = 32'(rec_len) - 32'd1;
  assign out_free  = !out_valid || pop;
  assign load_out  = busy && out_free;
  assign last      = (pos == '0);
  assign q_pop     = !busy && !q_status.empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (load_out && last) begin
        busy <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_win <= rec_data[WIN_W-1:0];
      pos     <= start_pos[IDX_W-1:0];
    end else if (load_out && !last) begin
      pos <= pos - IDX_W'(1);
    end
    if (load_out) begin
      match_byte <= cur_win[int'(pos)*CHAR_W +: CHAR_W];
      match_end  <= last;
    end
  end

  // Take a new record only once the previous one has finished
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !busy)
    else $error("record taken while another is in progress");

  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    (load_out && last) |=> !busy)
    else $error("back end still busy after the final byte");

  a_end_flag: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && (match_end == $past(last))))
    else $error("end marker does not follow the byte position");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (int'(pos) < PATTERN_MAX))
    else $error("byte position beyond the window");

endmodule

// ===== hw/rtl/wildcard_class_pattern_matcher_top.sv =====
// A text byte is checked in the cycle after it is accepted; a match is written to the
// record queue, loaded into the back end and registered onto the result ports, then
// one byte per cycle while pop is held high.
// Throughput: one text byte per cycle; input stalls only while a check waits behind a
// full record queue. The back end drains one record at a time.
// Reset (synchronous, rst high) clears configuration, window fill, the record queue and back end state.
module wildcard_class_pattern_matcher_top #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [wcpm_pkg::CHAR_W-1:0]     text_byte,
  input  logic                            string_start,
  input  logic                            push,
  output logic                            full,
  output logic [wcpm_pkg::CHAR_W-1:0]     match_byte,
  output logic                            match_end,
  output logic                            empty,
  input  logic                            pop,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wcpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wcpm_pkg::*;

  localparam int REC_W       = LEN_W + PATTERN_MAX * CHAR_W;
  localparam int QUEUE_DEPTH = 2;

  logic             rec_push;
  logic [REC_W-1:0] rec_wr_data;
  logic [REC_W-1:0] rec_rd_data;
  logic             rec_pop;
  q_status_t        q_status;

  wcpm_front #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .text_byte   (text_byte),
    .string_start(string_start),
    .push        (push),
    .full        (full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rec_push    (rec_push),
    .rec_data    (rec_wr_data),
    .q_status    (q_status)
  );

  wcpm_queue #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (rec_push),
    .wr_data(rec_wr_data),
    .rd_en  (rec_pop),
    .rd_data(rec_rd_data),
    .status (q_status)
  );

  wcpm_back #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_data  (rec_rd_data),
    .q_status  (q_status),
    .q_pop     (rec_pop),
    .match_byte(match_byte),
    .match_end (match_end),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for wildcard_class_pattern_matcher_top.
// Runs directed and random text against its own window predictor; needs
// wcpm_pkg and the matcher RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wcpm_pkg::*;

  localparam int WINDOW_DEPTH    = 16;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 10;
  localparam int PREDICT         = -1;   // hit count comes from the predictor only
  localparam int DIRECTED_ROWS   = 32;

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [CHAR_W-1:0]      ch;
    logic                   start;
    int                     hits;
  } stim_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } match_rec_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [CHAR_W-1:0]     text_byte = '0;
  logic                  string_start = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [CHAR_W-1:0]     match_byte;
  logic                  match_end;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [CHAR_W-1:0]     win_bytes [WINDOW_DEPTH];
  int                    win_fill = 0;
  logic [LEN_W-1:0]      pat_len = '0;
  logic [CFG_DATA_W-1:0] pat_low = '0;
  logic [CFG_DATA_W-1:0] pat_high = '0;
  match_rec_t            pending_matches [$];

  int mismatches = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int pop_stall_pct = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h61, 1'b1, 0},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, PREDICT},
    '{ROW_CFG,  REG_CHARS_LOW, 64'h0000_0000_0044_3F61, 8'h00, 1'b0, PREDICT},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "A", 1'b1, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "a", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "1", 1'b0, 3},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "2", 1'b0, 3},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd16, 8'h00, 1'b0, PREDICT},
    '{ROW_CFG,  REG_CHARS_LOW, 64'h443B_3A2D_2E2C_2141, 8'h00, 1'b0, PREDICT},
    '{ROW_CFG,  REG_CHARS_HIGH, 64'h3F3F_3F3F_3F3F_3F3F, 8'h00, 1'b0, PREDICT},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "z", 1'b1, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "!", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, ",", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, ".", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "-", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, ":", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, ";", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "9", 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hFF, 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h80, 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h7F, 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h01, 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hFE, 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h55, 1'b0, 0},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'hAA, 1'b0, 16},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, PREDICT},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 0},
    '{ROW_CFG,  REG_PATTERN_LENGTH, 64'd1, 8'h00, 1'b0, PREDICT},
    '{ROW_CFG,  REG_CHARS_LOW, 64'hFFFF_FFFF_FFFF_FF42, 8'h00, 1'b0, PREDICT},
    '{ROW_CFG,  REG_CHARS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, PREDICT},
    '{ROW_TEXT, REG_PATTERN_LENGTH, 64'd0, "B", 1'b1, 0}
  };

  wildcard_class_pattern_matcher_top #(
    .PATTERN_MAX(WINDOW_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .text_byte(text_byte),
    .string_start(string_start),
    .push(push),
    .full(full),
    .match_byte(match_byte),
    .match_end(match_end),
    .empty(empty),
    .pop(pop),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d matches outstanding",
               cycle_count, pending_matches.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [CHAR_W-1:0] pattern_char(input int k);
    return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
  endfunction

  function automatic logic lower_letter(input logic [CHAR_W-1:0] c);
    return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  endfunction

  function automatic logic char_ok(input logic [CHAR_W-1:0] c);
    logic ok;
    case (c)
      CH_ANY_LETTER, CH_ANY_DIGIT, CH_ANY_BYTE,
      CH_BANG, CH_COMMA, CH_DOT, CH_DASH, CH_COLON, CH_SEMI: ok = 1'b1;
      default: ok = lower_letter(c);
    endcase
    return ok;
  endfunction

  function automatic logic char_hit(input logic [CHAR_W-1:0] p, input logic [CHAR_W-1:0] t);
    logic hit;
    case (p)
      CH_ANY_LETTER: hit = lower_letter(t | CH_CASE_GAP);
      CH_ANY_DIGIT:  hit = (t >= CH_ZERO) && (t <= CH_NINE);
      CH_ANY_BYTE:   hit = 1'b1;
      default:       hit = lower_letter(p) ? ((t | CH_CASE_GAP) == p) : (t == p);
    endcase
    return hit;
  endfunction

  function automatic logic pattern_usable();
    logic ok;
    ok = (pat_len != 0) && (pat_len <= WINDOW_DEPTH);
    for (int k = 0; ok && k < pat_len; k++) begin
      ok = char_ok(pattern_char(k));
    end
    return ok;
  endfunction

  // Shift one byte into the window and queue the substring it completes, if any
  function automatic int take_byte(input logic [CHAR_W-1:0] b, input logic s);
    int n;
    logic hit;
    match_rec_t rec;
    if (s) begin
      win_fill = 0;
    end
    for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
      win_bytes[k] = win_bytes[k-1];
    end
    win_bytes[0] = b;
    if (win_fill < WINDOW_DEPTH) begin
      win_fill++;
    end
    n = int'(pat_len);
    hit = pattern_usable() && (win_fill >= n);
    for (int k = 0; hit && k < n; k++) begin
      hit = char_hit(pattern_char(k), win_bytes[n-1-k]);
    end
    if (!hit) begin
      return 0;
    end
    for (int k = 0; k < n; k++) begin
      rec.ch = win_bytes[n-1-k];
      rec.last = (k == n - 1);
      pending_matches.push_back(rec);
    end
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_pattern_char();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 5))
      0: c = CH_ANY_LETTER;
      1: c = CH_ANY_DIGIT;
      2: c = CH_ANY_BYTE;
      3: begin
        case ($urandom_range(0, 5))
          0: c = CH_BANG;
          1: c = CH_COMMA;
          2: c = CH_DOT;
          3: c = CH_DASH;
          4: c = CH_COLON;
          default: c = CH_SEMI;
        endcase
      end
      default: c = CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_bad_char();
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(0, 255));
    end while (char_ok(c));
    return c;
  endfunction

  // Text byte that satisfies pattern character p
  function automatic logic [CHAR_W-1:0] byte_for(input logic [CHAR_W-1:0] p);
    logic [CHAR_W-1:0] b;
    case (p)
      CH_ANY_LETTER: b = ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) +
                         CHAR_W'($urandom_range(0, 25));
      CH_ANY_DIGIT:  b = CH_ZERO + CHAR_W'($urandom_range(0, 9));
      CH_ANY_BYTE:   b = CHAR_W'($urandom_range(0, 255));
      default:       b = (lower_letter(p) && $urandom_range(0, 1)) ? (p - CH_CASE_GAP) : p;
    endcase
    return b;
  endfunction

  task automatic send_text(input logic [CHAR_W-1:0] b, input logic s, output int hits);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    text_byte <= b;
    string_start <= s;
    do @(posedge clk); while (full);
    hits = take_byte(b, s);
  endtask

  // Leaves cfg_valid high; the caller drops it once the burst of writes is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LENGTH: pat_len = value[LEN_W-1:0];
      REG_CHARS_LOW:      pat_low = value;
      REG_CHARS_HIGH:     pat_high = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    match_rec_t exp_rec;
    if (!rst && pop && !empty) begin
      if (pending_matches.size() == 0) begin
        flag_mismatch($sformatf("unexpected match byte %02h end %0b", match_byte, match_end));
      end else begin
        exp_rec = pending_matches.pop_front();
        if (match_byte !== exp_rec.ch) begin
          flag_mismatch($sformatf("match_byte %02h, predicted %02h", match_byte, exp_rec.ch));
        end
        if (match_end !== exp_rec.last) begin
          flag_mismatch($sformatf("match_end %0b, predicted %0b", match_end, exp_rec.last));
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  initial begin
    stim_row_t row;
    logic prev_text;
    logic lead;
    logic [LEN_W-1:0] len;
    logic [CHAR_W-1:0] chars [WINDOW_DEPTH];
    logic [CFG_DATA_W-1:0] lo, hi;
    int got, sent, r;

    foreach (win_bytes[k]) begin
      win_bytes[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    prev_text = 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        if (prev_text) begin
          wait_idle();
        end
        write_reg(row.idx, row.data);
        prev_text = 1'b0;
      end else begin
        cfg_valid <= 1'b0;
        send_text(row.ch, row.start, got);
        if (row.hits != PREDICT && got != row.hits) begin
          flag_mismatch($sformatf("directed row %0d: %0d matched bytes, table says %0d",
                                  i, got, row.hits));
        end
        prev_text = 1'b1;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_gap_pct = 67; pop_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  pop_stall_pct = 67; end
        default: begin send_gap_pct = 20; pop_stall_pct = 20; end
      endcase
      wait_idle();

      // Mostly short live patterns; a few empty, overlong or longer ones up to full width
      r = $urandom_range(0, 99);
      if (r < 5) begin
        len = '0;
      end else if (r < 12) begin
        len = LEN_W'($urandom_range(WINDOW_DEPTH + 1, 31));
      end else if (r < 25) begin
        len = LEN_W'($urandom_range(5, WINDOW_DEPTH));
      end else begin
        len = LEN_W'($urandom_range(1, 4));
      end
      foreach (chars[k]) begin
        chars[k] = pick_pattern_char();
      end
      if ($urandom_range(0, 9) == 0) begin
        chars[$urandom_range(0, 3)] = pick_bad_char();
      end
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = chars[k];
        hi[8*k +: 8] = chars[k+8];
      end
      write_reg(REG_PATTERN_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
      write_reg(REG_CHARS_LOW, lo);
      write_reg(REG_CHARS_HIGH, hi);
      cfg_valid <= 1'b0;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (pattern_usable() && $urandom_range(0, 99) < 70) begin
          lead = 1'($urandom_range(0, 1));
          for (int k = 0; k < pat_len; k++) begin
            send_text(byte_for(pattern_char(k)), lead && (k == 0), got);
            sent++;
          end
        end else begin
          send_text(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, got);
          sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/wcpm_pkg.sv
hw/rtl/wcpm_front.sv
hw/rtl/wcpm_queue.sv
hw/rtl/wcpm_back.sv
hw/rtl/wildcard_class_pattern_matcher_top.sv
verif/tb_top.sv
